// ===== sv/fmp_pkg.sv =====
package fmp_pkg;

  // Field widths of the two channels.
  localparam int N_BITS   = 60;
  localparam int MOD_BITS = 16;
  localparam int PER_BITS = 19;

  // The partial remainder has one bit more than the divisor.
  localparam int REM_BITS = PER_BITS + 1;
  localparam int CNT_BITS = $clog2(N_BITS);

  typedef struct packed {
    logic [N_BITS-1:0]   n_index;
    logic [MOD_BITS-1:0] modulus;
  } in_item_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] residue;
    logic [PER_BITS-1:0] period;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk_step;
    logic pair_step;
    logic pair_init;
    logic set_period;
    logic clr_period;
    logic div_init;
    logic div_step;
    logic rem_dec;
    logic capture;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_small;
    logic k_eq_n;
    logic pair_back;
    logic div_last;
    logic cnt_zero;
  } status_t;

endpackage

// ===== sv/fibonacci_modulo_pisano_core.sv =====
// Channel   Ports                           Transaction
// input     in_valid, in_stall, in_data     index n_index and modulus
// output    out_valid, out_stall, out_data  residue F(n) mod m and Pisano period
//
// One transaction is worked on at a time. With k the walk length (the smaller of n
// and the period p), the pair is stepped k times; when the period is found first,
// the remainder unit forms n mod p one bit per cycle and the pair is then stepped
// n mod p times from the start. A single residue adder serves both walks.
// Modulus 0 or 1 skips the walk; the period reads 0 whenever it was not found.
// Reset is synchronous and active low and clears only the controller. A stalled
// result waits in the output register, and the next transaction is accepted while it waits.
module fibonacci_modulo_pisano_core import fmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Command and status buses between the sequencer and the arithmetic.
  cmd_t    cmd;
  status_t sts;

  // The controller walks the pair until the index or the period is hit, then
  // runs the remainder and the second walk when the period came first.
  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the residue pair, the step counter, the remainder
  // unit and the output register.
  fmp_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== sv/fmp_ctrl.sv =====
module fmp_ctrl import fmp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DIV  = 5'b00100,
    S_STEP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.m_small || sts.k_eq_n) begin
          cmd.clr_period = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.pair_step = 1'b1;
          cmd.walk_step = 1'b1;
          if (sts.pair_back) begin
            cmd.set_period = 1'b1;
            cmd.div_init   = 1'b1;
            state_nxt      = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.pair_init = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.cnt_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pair_step = 1'b1;
          cmd.rem_dec   = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/fmp_dp.sv =====
module fmp_dp import fmp_pkg::*; (
  input  logic      clk,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   sts,
  output out_item_t out_data
);

  logic [N_BITS-1:0]   n_r;
  logic [N_BITS-1:0]   nsh_r;
  logic [MOD_BITS-1:0] m_r;
  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic [PER_BITS-1:0] k_r;
  logic [PER_BITS-1:0] period_r;
  logic [REM_BITS-1:0] rem_r;
  logic [CNT_BITS-1:0] bitcnt_r;
  out_item_t           out_r;

  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS-1:0] t_next;
  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] rem_nxt;

  // Next Fibonacci residue: a + b is below 2m, so one subtract reduces it.
  always_comb begin
    sum = {1'b0, a_r} + {1'b0, b_r};
    if (sum >= {1'b0, m_r}) begin
      t_next = MOD_BITS'(sum - {1'b0, m_r});
    end else begin
      t_next = sum[MOD_BITS-1:0];
    end
  end

  // One restoring step of n mod period, most significant bit first.
  always_comb begin
    rem_sh = {rem_r[REM_BITS-2:0], nsh_r[N_BITS-1]};
    if (rem_sh >= {1'b0, period_r}) begin
      rem_nxt = rem_sh - {1'b0, period_r};
    end else begin
      rem_nxt = rem_sh;
    end
  end

  always_comb begin
    sts.m_small   = (m_r < MOD_BITS'(2));
    sts.k_eq_n    = (N_BITS'(k_r) == n_r);
    sts.pair_back = (b_r == '0) && (t_next == MOD_BITS'(1));
    sts.div_last  = (bitcnt_r == CNT_BITS'(N_BITS - 1));
    sts.cnt_zero  = (rem_r == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= in_data.n_index;
      m_r <= in_data.modulus;
      k_r <= '0;
    end
    if (cmd.load || cmd.pair_init) begin
      a_r <= '0;
      b_r <= MOD_BITS'(1);
    end else if (cmd.pair_step) begin
      a_r <= b_r;
      b_r <= t_next;
    end
    if (cmd.walk_step) begin
      k_r <= k_r + PER_BITS'(1);
    end
    if (cmd.set_period) begin
      period_r <= k_r + PER_BITS'(1);
    end else if (cmd.clr_period) begin
      period_r <= '0;
    end
    if (cmd.div_init) begin
      rem_r    <= '0;
      nsh_r    <= n_r;
      bitcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= rem_nxt;
      nsh_r    <= {nsh_r[N_BITS-2:0], 1'b0};
      bitcnt_r <= bitcnt_r + CNT_BITS'(1);
    end else if (cmd.rem_dec) begin
      rem_r <= rem_r - REM_BITS'(1);
    end
    if (cmd.capture) begin
      out_r.residue <= a_r;
      out_r.period  <= period_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/fmp_checker.sv =====
module fmp_checker import fmp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only one transaction is in work, so an accepted one closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // The residue is below the modulus, which never exceeds its field's maximum.
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.residue != {MOD_BITS{1'b1}})
    else $error("residue out of range");

  // A Pisano period, when found, is at least three.
  a_period_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.period == '0 || out_data.period >= PER_BITS'(3))
    else $error("period too short");

endmodule

bind fibonacci_modulo_pisano_core fmp_checker u_fmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
